@@ rtl/dcvs_pkg.sv @@
package dcvs_pkg;

  localparam int unsigned HEADER_BYTES = 24;
  localparam int unsigned ENTRY_BYTES  = 24;

  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned TABLE_END_W = 42;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_OK        = 3'd1,
    ST_INVALID   = 3'd2,
    ST_VERSION   = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_OVERFLOW  = 3'd5,
    ST_NOT_FOUND = 3'd6,
    ST_SEQUENCE  = 3'd7
  } status_e;

  typedef enum logic {
    MODE_HEADER = 1'b0,
    MODE_ENTRY  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e       mode;
    logic [63:0] catalog_length;
    logic [31:0] wanted_ordinal;
    logic [31:0] header_magic;
    logic [15:0] header_version;
    logic [31:0] item_flags;
    logic [31:0] header_reserved;
    logic [31:0] entry_count;
    logic [31:0] entry_ordinal;
    logic [63:0] entry_offset;
    logic [63:0] entry_length;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        walk_done;
    logic [63:0] selected_offset;
    logic [63:0] selected_length;
  } result_t;

endpackage

@@ rtl/dcvs_core.sv @@
module dcvs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  dcvs_pkg::item_t  item_i,
  input  logic [31:0]      expected_magic_i,
  input  logic [15:0]      expected_version_i,
  output dcvs_pkg::result_t res_o
);
  import dcvs_pkg::*;

  logic        walk_active_q, walk_active_d;
  logic [31:0] entry_index_q, entry_index_d;
  logic [31:0] entry_total_q, entry_total_d;
  logic [63:0] total_bytes_q, total_bytes_d;
  logic [31:0] target_ordinal_q, target_ordinal_d;
  logic [63:0] next_data_offset_q, next_data_offset_d;
  logic        match_found_q, match_found_d;
  logic [63:0] match_offset_q, match_offset_d;
  logic [63:0] match_length_q, match_length_d;

  logic [TABLE_END_W-1:0] table_end;
  logic [TABLE_END_W-1:0] table_end_up;
  logic [64:0]            data_end_w;
  logic [63:0]            data_end;
  logic [63:0]            data_end_up;
  logic                   end_ovf;
  logic [31:0]            index_inc;
  logic                   hit;

  assign table_end = TABLE_END_W'(HEADER_BYTES)
                   + TABLE_END_W'(item_i.entry_count) * TABLE_END_W'(ENTRY_BYTES);
  assign table_end_up = {table_end[TABLE_END_W-1:3] + (TABLE_END_W-3)'(|table_end[2:0]),
                         3'b000};

  assign data_end_w  = {1'b0, item_i.entry_offset} + {1'b0, item_i.entry_length};
  assign data_end    = data_end_w[63:0];
  assign end_ovf     = (&data_end[63:3]) && (|data_end[2:0]);
  assign data_end_up = {data_end[63:3] + 61'(|data_end[2:0]), 3'b000};
  assign index_inc   = entry_index_q + 32'd1;
  assign hit         = (item_i.entry_ordinal == target_ordinal_q);

  always_comb begin
    walk_active_d      = walk_active_q;
    entry_index_d      = entry_index_q;
    entry_total_d      = entry_total_q;
    total_bytes_d      = total_bytes_q;
    target_ordinal_d   = target_ordinal_q;
    next_data_offset_d = next_data_offset_q;
    match_found_d      = match_found_q;
    match_offset_d     = match_offset_q;
    match_length_d     = match_length_q;
    res_o              = '{status: ST_ACCEPTED, walk_done: 1'b0,
                           selected_offset: '0, selected_length: '0};

    if (item_i.mode == MODE_HEADER) begin
      walk_active_d  = 1'b0;
      match_found_d  = 1'b0;
      match_offset_d = '0;
      match_length_d = '0;
      res_o.walk_done = 1'b1;
      priority if (item_i.catalog_length < 64'(HEADER_BYTES)) begin
        res_o.status = ST_INVALID;
      end else if (item_i.header_magic != expected_magic_i) begin
        res_o.status = ST_INVALID;
      end else if (item_i.header_version != expected_version_i) begin
        res_o.status = ST_VERSION;
      end else if (item_i.item_flags != '0 || item_i.header_reserved != '0) begin
        res_o.status = ST_INVALID;
      end else if (item_i.entry_count == '0) begin
        res_o.status = ST_EMPTY;
      end else if (item_i.catalog_length < 64'(table_end)) begin
        res_o.status = ST_INVALID;
      end else begin
        res_o.walk_done    = 1'b0;
        walk_active_d      = 1'b1;
        entry_index_d      = '0;
        entry_total_d      = item_i.entry_count;
        total_bytes_d      = item_i.catalog_length;
        target_ordinal_d   = item_i.wanted_ordinal;
        next_data_offset_d = 64'(table_end_up);
      end
    end else if (!walk_active_q) begin
      res_o.status    = ST_SEQUENCE;
      res_o.walk_done = 1'b1;
    end else begin
      res_o.walk_done = 1'b1;
      walk_active_d   = 1'b0;
      priority if (item_i.entry_ordinal != entry_index_q) begin
        res_o.status = ST_INVALID;
      end else if (item_i.item_flags != '0) begin
        res_o.status = ST_INVALID;
      end else if (item_i.entry_length == '0) begin
        res_o.status = ST_INVALID;
      end else if (item_i.entry_offset[2:0] != 3'b000) begin
        res_o.status = ST_INVALID;
      end else if (item_i.entry_offset < next_data_offset_q) begin
        res_o.status = ST_INVALID;
      end else if (data_end_w[64]) begin
        res_o.status = ST_INVALID;
      end else if (data_end > total_bytes_q) begin
        res_o.status = ST_INVALID;
      end else if (end_ovf) begin
        res_o.status = ST_OVERFLOW;
      end else begin
        next_data_offset_d = data_end_up;
        entry_index_d      = index_inc;
        if (hit) begin
          match_found_d  = 1'b1;
          match_offset_d = item_i.entry_offset;
          match_length_d = item_i.entry_length;
        end
        priority if (index_inc != entry_total_q) begin
          res_o.status    = ST_ACCEPTED;
          res_o.walk_done = 1'b0;
          walk_active_d   = 1'b1;
        end else if (data_end_up != total_bytes_q) begin
          res_o.status = ST_INVALID;
        end else if (!match_found_d) begin
          res_o.status = ST_NOT_FOUND;
        end else begin
          res_o.status          = ST_OK;
          res_o.selected_offset = match_offset_d;
          res_o.selected_length = match_length_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_active_q      <= 1'b0;
      entry_index_q      <= '0;
      entry_total_q      <= '0;
      total_bytes_q      <= '0;
      target_ordinal_q   <= '0;
      next_data_offset_q <= '0;
      match_found_q      <= 1'b0;
      match_offset_q     <= '0;
      match_length_q     <= '0;
    end else if (step_i) begin
      walk_active_q      <= walk_active_d;
      entry_index_q      <= entry_index_d;
      entry_total_q      <= entry_total_d;
      total_bytes_q      <= total_bytes_d;
      target_ordinal_q   <= target_ordinal_d;
      next_data_offset_q <= next_data_offset_d;
      match_found_q      <= match_found_d;
      match_offset_q     <= match_offset_d;
      match_length_q     <= match_length_d;
    end
  end

endmodule

@@ rtl/dcvs_out_stage.sv @@
module dcvs_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_valid_i,
  input  dcvs_pkg::result_t res_i,
  output logic              free_o,
  input  logic              stall_i,
  output logic              valid_o,
  output dcvs_pkg::result_t res_o
);
  import dcvs_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

@@ rtl/device_catalog_validate_select.sv @@
// Channel   | Handshake                     | Payload
// ----------+-------------------------------+-------------------------------------------
// input     | in_valid_i / in_stall_o       | mode_i .. entry_length_i (one item)
// result    | out_valid_o / out_stall_i     | status_o, walk_done_o, selected_*_o
// config    | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; an accepted item passes
// through the input register and then the result register before out_valid_o rises.
// The input register and the result register bound one pass of the checking logic,
// which also updates the walk state in the same cycle.
// Reset clears the walk state and both valid flags; configuration resets to zero.
// A stalled result holds the result register and, behind it, the input register.
module device_catalog_validate_select (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                mode_i,
  input  logic [63:0]                         catalog_length_i,
  input  logic [31:0]                         wanted_ordinal_i,
  input  logic [31:0]                         header_magic_i,
  input  logic [15:0]                         header_version_i,
  input  logic [31:0]                         item_flags_i,
  input  logic [31:0]                         header_reserved_i,
  input  logic [31:0]                         entry_count_i,
  input  logic [31:0]                         entry_ordinal_i,
  input  logic [63:0]                         entry_offset_i,
  input  logic [63:0]                         entry_length_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          status_o,
  output logic                                walk_done_o,
  output logic [63:0]                         selected_offset_o,
  output logic [63:0]                         selected_length_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dcvs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dcvs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import dcvs_pkg::*;

  logic        s1_valid_q;
  item_t       s1_item_q;
  item_t       in_item;
  logic        out_free;
  logic        step;
  result_t     core_res;
  result_t     out_res;
  logic [31:0] expected_magic_q;
  logic [15:0] expected_version_q;

  assign in_item = '{mode: mode_e'(mode_i), catalog_length: catalog_length_i,
                     wanted_ordinal: wanted_ordinal_i, header_magic: header_magic_i,
                     header_version: header_version_i, item_flags: item_flags_i,
                     header_reserved: header_reserved_i, entry_count: entry_count_i,
                     entry_ordinal: entry_ordinal_i, entry_offset: entry_offset_i,
                     entry_length: entry_length_i};

  assign in_stall_o  = s1_valid_q && !out_free;
  assign step        = s1_valid_q && out_free;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_item_q <= in_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_magic_q   <= '0;
      expected_version_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_MAGIC:   expected_magic_q   <= cfg_data_i;
        CFG_VERSION: expected_version_q <= cfg_data_i[15:0];
        default:     expected_magic_q   <= expected_magic_q;
      endcase
    end
  end

  dcvs_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .item_i             (s1_item_q),
    .expected_magic_i   (expected_magic_q),
    .expected_version_i (expected_version_q),
    .res_o              (core_res)
  );

  dcvs_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (s1_valid_q),
    .res_i        (core_res),
    .free_o       (out_free),
    .stall_i      (out_stall_i),
    .valid_o      (out_valid_o),
    .res_o        (out_res)
  );

  assign status_o          = out_res.status;
  assign walk_done_o       = out_res.walk_done;
  assign selected_offset_o = out_res.selected_offset;
  assign selected_length_o = out_res.selected_length;

endmodule

@@ dv/device_catalog_validate_select_tb.sv @@
`timescale 1ns / 100ps

module device_catalog_validate_select_tb;
  import dcvs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned MAX_ENTRIES = 12;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam logic [63:0] ALIGN_TOP   = 64'hFFFF_FFFF_FFFF_FFF8;

  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_HDR_FLAGS,
    FLAW_RESERVED,
    FLAW_EMPTY,
    FLAW_SHORT_TABLE,
    FLAW_SHORT_LEN,
    FLAW_ORDINAL,
    FLAW_ENT_FLAGS,
    FLAW_ZERO_LEN,
    FLAW_MISALIGN,
    FLAW_OVERLAP,
    FLAW_PAST_END,
    FLAW_WRAP,
    FLAW_ALIGN_OVF,
    FLAW_TRAILING,
    FLAW_MISSING,
    FLAW_TRUNCATE,
    FLAW_EXTRA
  } flaw_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  item_t drv = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic walk_done;
  logic [63:0] sel_off;
  logic [63:0] sel_len;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MAGIC;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  item_t item_q [$];
  result_t verdict_q [$];

  // predictor copy of registers and walk state
  logic [31:0] cfg_magic = '0;
  logic [15:0] cfg_version = '0;
  logic walk_on = 1'b0;
  logic [31:0] walk_idx = '0;
  logic [31:0] walk_total = '0;
  logic [63:0] walk_bytes = '0;
  logic [31:0] walk_target = '0;
  logic [63:0] data_end = '0;
  logic pick_hit = 1'b0;
  logic [63:0] pick_off = '0;
  logic [63:0] pick_len = '0;

  int unsigned n_pushed = 0;
  int unsigned n_accepted = 0;
  int unsigned n_results = 0;
  int unsigned n_errors = 0;
  int unsigned n_catalogs = 0;
  int unsigned status_seen [8] = '{default: 0};
  int unsigned quiet = 0;

  bit in_took = 1'b0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  bit rx_hold_done = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_wait = 0;

  device_catalog_validate_select DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .mode_i            (drv.mode),
    .catalog_length_i  (drv.catalog_length),
    .wanted_ordinal_i  (drv.wanted_ordinal),
    .header_magic_i    (drv.header_magic),
    .header_version_i  (drv.header_version),
    .item_flags_i      (drv.item_flags),
    .header_reserved_i (drv.header_reserved),
    .entry_count_i     (drv.entry_count),
    .entry_ordinal_i   (drv.entry_ordinal),
    .entry_offset_i    (drv.entry_offset),
    .entry_length_i    (drv.entry_length),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .status_o          (status),
    .walk_done_o       (walk_done),
    .selected_offset_o (sel_off),
    .selected_length_o (sel_len),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic result_t judge_item(item_t it);
    result_t r;
    logic [63:0] tbl_end;
    logic [63:0] stop;
    r = '0;
    r.status = ST_ACCEPTED;
    if (it.mode == MODE_HEADER) begin
      walk_on = 1'b0;
      pick_hit = 1'b0;
      pick_off = '0;
      pick_len = '0;
      tbl_end = 64'(HEADER_BYTES) + 64'(it.entry_count) * 64'(ENTRY_BYTES);
      if (it.catalog_length < 64'(HEADER_BYTES) || it.header_magic != cfg_magic) begin
        r.status = ST_INVALID;
      end else if (it.header_version != cfg_version) begin
        r.status = ST_VERSION;
      end else if (it.item_flags != '0 || it.header_reserved != '0) begin
        r.status = ST_INVALID;
      end else if (it.entry_count == '0) begin
        r.status = ST_EMPTY;
      end else if (it.catalog_length < tbl_end) begin
        r.status = ST_INVALID;
      end else begin
        walk_on = 1'b1;
        walk_idx = '0;
        walk_total = it.entry_count;
        walk_bytes = it.catalog_length;
        walk_target = it.wanted_ordinal;
        data_end = (tbl_end + 64'd7) & ~64'd7;
      end
    end else if (!walk_on) begin
      r.status = ST_SEQUENCE;
    end else begin
      stop = it.entry_offset + it.entry_length;
      if (it.entry_ordinal != walk_idx || it.item_flags != '0 || it.entry_length == '0 ||
          it.entry_offset[2:0] != 3'd0 || it.entry_offset < data_end ||
          it.entry_length > ~it.entry_offset || stop > walk_bytes) begin
        r.status = ST_INVALID;
      end else if (stop > ALIGN_TOP) begin
        r.status = ST_OVERFLOW;
      end else begin
        data_end = (stop + 64'd7) & ~64'd7;
        if (it.entry_ordinal == walk_target) begin
          pick_hit = 1'b1;
          pick_off = it.entry_offset;
          pick_len = it.entry_length;
        end
        walk_idx = walk_idx + 32'd1;
        if (walk_idx == walk_total) begin
          if (data_end != walk_bytes) begin
            r.status = ST_INVALID;
          end else if (!pick_hit) begin
            r.status = ST_NOT_FOUND;
          end else begin
            r.status = ST_OK;
            r.selected_offset = pick_off;
            r.selected_length = pick_len;
          end
        end
      end
    end
    if (r.status != ST_ACCEPTED) begin
      r.walk_done = 1'b1;
      walk_on = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.mode            = mode_e'($urandom_range(0, 1));
    it.catalog_length  = {$urandom, $urandom};
    it.wanted_ordinal  = $urandom;
    it.header_magic    = $urandom;
    it.header_version  = 16'($urandom);
    it.item_flags      = $urandom;
    it.header_reserved = $urandom;
    it.entry_count     = $urandom;
    it.entry_ordinal   = $urandom;
    it.entry_offset    = {$urandom, $urandom};
    it.entry_length    = {$urandom, $urandom};
    if (it.mode == MODE_HEADER && $urandom_range(0, 1) == 1) begin
      it.header_magic    = cfg_magic;
      it.header_version  = cfg_version;
      it.item_flags      = '0;
      it.header_reserved = '0;
    end
    return it;
  endfunction

  task automatic queue_item(item_t it);
    item_q.push_back(it);
    n_pushed++;
  endtask

  task automatic queue_catalog(int unsigned n, flaw_e flaw, bit far);
    item_t hdr;
    item_t ent [MAX_ENTRIES];
    logic [63:0] free_at [MAX_ENTRIES];
    logic [63:0] pos;
    item_t e;
    int unsigned k;
    int unsigned keep;
    hdr = random_item();
    hdr.mode = MODE_HEADER;
    hdr.header_magic = cfg_magic;
    hdr.header_version = cfg_version;
    hdr.item_flags = '0;
    hdr.header_reserved = '0;
    hdr.entry_count = n;
    hdr.wanted_ordinal = $urandom_range(0, n - 1);
    pos = (64'(HEADER_BYTES) + 64'(n) * 64'(ENTRY_BYTES) + 64'd7) & ~64'd7;
    if (far) pos = pos + (({$urandom, $urandom} >> 3) & ~64'd7);
    for (int i = 0; i < n; i++) begin
      e = random_item();
      e.mode = MODE_ENTRY;
      e.entry_ordinal = i;
      e.item_flags = '0;
      free_at[i] = pos;
      e.entry_offset = pos + 64'(8 * $urandom_range(0, 3));
      e.entry_length = far ? 64'($urandom) + 64'd1 : 64'($urandom_range(1, 64));
      pos = (e.entry_offset + e.entry_length + 64'd7) & ~64'd7;
      ent[i] = e;
    end
    hdr.catalog_length = pos;
    keep = n;
    k = $urandom_range(0, n - 1);
    case (flaw)
      FLAW_MAGIC:       hdr.header_magic ^= 32'd1 << $urandom_range(0, 31);
      FLAW_VERSION:     hdr.header_version ^= 16'd1 << $urandom_range(0, 15);
      FLAW_HDR_FLAGS:   hdr.item_flags = 32'd1 << $urandom_range(0, 31);
      FLAW_RESERVED:    hdr.header_reserved = 32'd1 << $urandom_range(0, 31);
      FLAW_EMPTY:       hdr.entry_count = '0;
      FLAW_SHORT_TABLE: begin
        hdr.catalog_length = 64'(HEADER_BYTES) + 64'(n) * 64'(ENTRY_BYTES)
                             - 64'($urandom_range(1, ENTRY_BYTES - 1));
      end
      FLAW_SHORT_LEN:   hdr.catalog_length = 64'($urandom_range(0, HEADER_BYTES - 1));
      FLAW_ORDINAL:     ent[k].entry_ordinal ^= 32'd1 << $urandom_range(0, 31);
      FLAW_ENT_FLAGS:   ent[k].item_flags = $urandom | (32'd1 << $urandom_range(0, 31));
      FLAW_ZERO_LEN:    ent[k].entry_length = '0;
      FLAW_MISALIGN:    ent[k].entry_offset += 64'($urandom_range(1, 7));
      FLAW_OVERLAP:     ent[k].entry_offset = free_at[k] - 64'd8;
      FLAW_PAST_END:    ent[n-1].entry_length += 64'(8 + $urandom_range(0, 16));
      FLAW_WRAP:        ent[k].entry_length = ~ent[k].entry_offset + 64'($urandom_range(1, 8));
      FLAW_ALIGN_OVF: begin
        hdr.catalog_length = '1;
        ent[n-1].entry_offset = ALIGN_TOP;
        ent[n-1].entry_length = 64'($urandom_range(1, 7));
      end
      FLAW_TRAILING:    hdr.catalog_length += 64'($urandom_range(1, 32));
      FLAW_MISSING:     hdr.wanted_ordinal = n + $urandom_range(0, 32'hFFFF);
      FLAW_TRUNCATE:    keep = k;
      default: ;
    endcase
    queue_item(hdr);
    for (int i = 0; i < keep; i++) queue_item(ent[i]);
    if (flaw == FLAW_EXTRA) begin
      e = random_item();
      e.mode = MODE_ENTRY;
      queue_item(e);
    end
    n_catalogs++;
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_MAGIC) cfg_magic = val;
    else cfg_version = val[15:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_regs(logic [31:0] magic, logic [15:0] version);
    write_reg(CFG_MAGIC, magic);
    write_reg(CFG_VERSION, {16'd0, version});
  endtask

  task automatic settle();
    do @(negedge clk); while (n_accepted != n_pushed || verdict_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    item_t nxt;
    if (rst_n && (!in_valid || in_took)) begin
      if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        nxt = item_q.pop_front();
        drv <= nxt;
        in_valid <= 1'b1;
        tx_gap <= (tx_idle_en && $urandom_range(0, 9) < 3) ? idle_len() : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rst_n) begin
      if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_stall <= 1'b1;
      end else if (!rx_hold_done && !tx_idle_en && n_pushed - n_accepted > 20) begin
        rx_hold_done <= 1'b1;
        rx_wait <= 79;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        rx_wait <= idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    result_t want;
    result_t got;
    in_took <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.status = status_e'(status);
        got.walk_done = walk_done;
        got.selected_offset = sel_off;
        got.selected_length = sel_len;
        n_results++;
        status_seen[status]++;
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result, status %0d walk_done %0b", $time, status, walk_done);
          n_errors++;
        end else begin
          want = verdict_q.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %s actual %0d", $time, want.status.name(), status);
            n_errors++;
          end
          if (got.walk_done != want.walk_done) begin
            $display("%0t: walk_done expected %0b actual %0b", $time, want.walk_done,
                     got.walk_done);
            n_errors++;
          end
          if (got.selected_offset != want.selected_offset) begin
            $display("%0t: selected_offset expected %h actual %h", $time,
                     want.selected_offset, got.selected_offset);
            n_errors++;
          end
          if (got.selected_length != want.selected_length) begin
            $display("%0t: selected_length expected %h actual %h", $time,
                     want.selected_length, got.selected_length);
            n_errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        verdict_q.push_back(judge_item(drv));
        n_accepted++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    flaw_e first_flaws [11];
    item_t it;
    int unsigned mark;
    first_flaws = '{FLAW_NONE, FLAW_MAGIC, FLAW_VERSION, FLAW_HDR_FLAGS, FLAW_EMPTY,
                    FLAW_SHORT_TABLE, FLAW_ALIGN_OVF, FLAW_WRAP, FLAW_MISSING,
                    FLAW_TRAILING, FLAW_TRUNCATE};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    program_regs($urandom, 16'($urandom));
    @(posedge clk);
    it = random_item();
    it.mode = MODE_ENTRY;
    queue_item(it);
    // widest table the count allows, then an entry whose end cannot be aligned
    it = random_item();
    it.mode = MODE_HEADER;
    it.catalog_length = '1;
    it.wanted_ordinal = '1;
    it.header_magic = cfg_magic;
    it.header_version = cfg_version;
    it.item_flags = '0;
    it.header_reserved = '0;
    it.entry_count = '1;
    queue_item(it);
    it = random_item();
    it.mode = MODE_ENTRY;
    it.entry_ordinal = '0;
    it.item_flags = '0;
    it.entry_offset = ALIGN_TOP;
    it.entry_length = 64'd7;
    queue_item(it);
    foreach (first_flaws[i]) begin
      queue_catalog((first_flaws[i] == FLAW_TRUNCATE) ? 2 : 1, first_flaws[i], 1'b0);
    end

    for (int p = 1; p <= 5; p++) begin
      settle();
      case (p)
        1: program_regs('0, '0);
        2: program_regs('1, '1);
        default: program_regs($urandom, 16'($urandom));
      endcase
      @(posedge clk);
      tx_idle_en = (p != 2 && p != 4);
      rx_idle_en = (p == 1 || p >= 4);
      mark = n_pushed;
      while (n_pushed - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_item(random_item());
        end else begin
          queue_catalog(($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_ENTRIES)
                                                    : $urandom_range(1, 4),
                        ($urandom_range(0, 9) < 6) ? FLAW_NONE
                                                   : flaw_e'($urandom_range(FLAW_MAGIC,
                                                                            FLAW_EXTRA)),
                        $urandom_range(0, 6) == 0);
        end
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, verdict_q.size());
      n_errors++;
    end
    $display("Sent %0d items in %0d catalogs under six register settings;",
             n_accepted, n_catalogs);
    $display("  %0d results, %0d mismatches", n_results, n_errors);
    $display("Statuses: accepted %0d ok %0d invalid %0d version %0d",
             status_seen[ST_ACCEPTED], status_seen[ST_OK], status_seen[ST_INVALID],
             status_seen[ST_VERSION]);
    $display("  empty %0d overflow %0d notfound %0d sequence %0d",
             status_seen[ST_EMPTY], status_seen[ST_OVERFLOW], status_seen[ST_NOT_FOUND],
             status_seen[ST_SEQUENCE]);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
